// ===== rtl/dnle_pkg.sv =====
// dnle_pkg: shared types and constants of the DNS name label encoder.
// No dependencies.
`default_nettype none
package dnle_pkg;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam int unsigned ENC_W    = 8;
    localparam int unsigned OQ_DEPTH = 4;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_EMPTY      = 2'd1;
    localparam logic [1:0] ERR_LONG_LABEL = 2'd2;
    localparam logic [1:0] ERR_LONG_NAME  = 2'd3;

    localparam logic [1:0] CMD_LABEL = 2'd0;
    localparam logic [1:0] CMD_TERM  = 2'd1;
    localparam logic [1:0] CMD_ERR   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] len;
        logic       bank;
        logic       last;
        logic [1:0] err;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_name;
        logic [1:0] err_code;
    } t_res;

endpackage
`default_nettype wire

// ===== rtl/dnle_ram.sv =====
// dnle_ram: generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module dnle_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dnle_front.sv =====
// dnle_front: accepts characters, tracks label and name state, buffers
// label bytes and issues commands. Depends on dnle_pkg.
`default_nettype none
module dnle_front import dnle_pkg::*; #(
    parameter int unsigned MAX_LABEL   = 62,
    parameter int unsigned MAX_ENCODED = 128,
    localparam int unsigned LCW = $clog2(MAX_LABEL + 1)
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  wire [7:0]       i_ch,
    input  wire             i_final_char,
    output logic            o_full,
    input  t_q_status       i_q_status,
    output logic            o_cmd_push,
    output t_cmd            o_cmd,
    input  t_release        i_release,
    output logic            o_we,
    output logic [LCW:0]    o_waddr,
    output logic [7:0]      o_wdata
);
    logic [LCW-1:0]   r_cnt, n_cnt;
    logic [ENC_W-1:0] r_enc, n_enc;
    logic [1:0]       r_err, n_err;
    logic             r_start, n_start;
    logic             r_bank, n_bank;
    logic [1:0]       r_busy, n_busy;

    logic             accept, is_dot, store, want_close, too_long, close_ok;
    logic [1:0]       err_new, err_eff;
    logic [LCW-1:0]   cnt_after;

    assign o_full  = i_q_status.full | r_busy[r_bank];
    assign accept  = i_push & ~o_full;
    assign is_dot  = (i_ch == DOT_CHAR);

    always_comb begin
        err_new   = ERR_NONE;
        store     = 1'b0;
        cnt_after = r_cnt;
        if (is_dot) begin
            if (r_cnt == '0 && !(i_final_char && r_start)) begin
                err_new = ERR_EMPTY;
            end
        end else if (r_cnt >= LCW'(MAX_LABEL)) begin
            err_new = ERR_LONG_LABEL;
        end else begin
            store     = 1'b1;
            cnt_after = r_cnt + LCW'(1);
        end
        want_close = (err_new == ERR_NONE) &&
                     ((is_dot && r_cnt != '0) || (i_final_char && cnt_after != '0));
        too_long   = ({1'b0, r_enc} + 9'(cnt_after) + 9'd2) > 9'(MAX_ENCODED);
        close_ok   = want_close && !too_long && (r_err == ERR_NONE);
        if (r_err != ERR_NONE) begin
            err_eff = r_err;
            store   = 1'b0;
        end else if (want_close && too_long) begin
            err_eff = ERR_LONG_NAME;
        end else begin
            err_eff = err_new;
        end
    end

    always_comb begin
        o_cmd      = '{kind: CMD_TERM, len: 8'(cnt_after), bank: r_bank,
                       last: i_final_char, err: err_eff};
        o_cmd_push = 1'b0;
        if (accept) begin
            if (i_final_char) begin
                o_cmd_push = 1'b1;
                if (err_eff != ERR_NONE) begin
                    o_cmd.kind = CMD_ERR;
                end else if (close_ok) begin
                    o_cmd.kind = CMD_LABEL;
                end
            end else if (close_ok) begin
                o_cmd_push = 1'b1;
                o_cmd.kind = CMD_LABEL;
            end
        end
    end

    assign o_we    = accept & store;
    assign o_waddr = {r_bank, r_cnt};
    assign o_wdata = i_ch;

    always_comb begin
        n_cnt   = r_cnt;
        n_enc   = r_enc;
        n_err   = r_err;
        n_start = r_start;
        n_bank  = r_bank;
        n_busy  = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept) begin
            if (close_ok) begin
                n_busy[r_bank] = 1'b1;
                n_bank         = ~r_bank;
            end
            if (i_final_char) begin
                n_cnt   = '0;
                n_enc   = '0;
                n_err   = ERR_NONE;
                n_start = 1'b1;
            end else begin
                n_err   = err_eff;
                n_start = 1'b0;
                n_cnt   = close_ok ? '0 : cnt_after;
                if (close_ok) begin
                    n_enc = r_enc + ENC_W'(cnt_after) + ENC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_enc   <= '0;
            r_err   <= ERR_NONE;
            r_start <= 1'b1;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_enc   <= n_enc;
            r_err   <= n_err;
            r_start <= n_start;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dnle_cmdq.sv =====
// dnle_cmdq: two entry command queue between front and back.
// Depends on dnle_pkg.
`default_nettype none
module dnle_cmdq import dnle_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_cmd       i_cmd,
    input  wire        i_pop,
    output t_cmd       o_cmd,
    output t_q_status  o_status
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_cmd          = r_mem[r_rp];
    assign o_status.empty = (r_cnt == 2'd0);
    assign o_status.full  = (r_cnt == 2'd2);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dnle_back.sv =====
// dnle_back: runs commands, replays label bytes from the label RAM and
// queues results for the consumer. Depends on dnle_pkg.
`default_nettype none
module dnle_back import dnle_pkg::*; #(
    parameter int unsigned MAX_LABEL = 62,
    localparam int unsigned LCW = $clog2(MAX_LABEL + 1)
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  t_q_status       i_q_status,
    input  t_cmd            i_cmd,
    output logic            o_cmd_pop,
    output t_release        o_release,
    output logic            o_re,
    output logic [LCW:0]    o_raddr,
    input  wire [7:0]       i_rdata,
    input  wire             i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_end_of_name,
    output logic [1:0]      o_err_code
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_DATA = 3'd2;
    localparam logic [2:0] ST_TERM = 3'd3;
    localparam logic [2:0] ST_ERR  = 3'd4;
    localparam int unsigned OPW = $clog2(OQ_DEPTH);

    logic [2:0]     r_state, n_state;
    t_cmd           r_cmd;
    logic [LCW-1:0] r_idx;
    logic           r_rd_pend;

    t_res           r_oq [OQ_DEPTH];
    logic [OPW-1:0] r_owp, r_orp;
    logic [OPW:0]   r_ocnt;

    logic  can_direct, can_read, direct, last_rd, oq_wr, oq_rd;
    t_res  direct_res, wr_res;

    assign can_direct = !r_rd_pend && (r_ocnt < (OPW+1)'(OQ_DEPTH));
    assign can_read   = ((r_ocnt + (OPW+1)'(r_rd_pend)) < (OPW+1)'(OQ_DEPTH));
    assign last_rd    = (8'(r_idx) + 8'd1) == r_cmd.len;
    assign o_cmd_pop  = (r_state == ST_IDLE) && !i_q_status.empty;
    assign o_re       = (r_state == ST_DATA) && can_read;
    assign o_raddr    = {r_cmd.bank, r_idx};
    assign o_release  = '{valid: o_re && last_rd, bank: r_cmd.bank};

    always_comb begin
        n_state    = r_state;
        direct     = 1'b0;
        direct_res = '{out_byte: 8'd0, end_of_name: 1'b1, err_code: ERR_NONE};
        case (r_state)
            ST_IDLE: begin
                if (o_cmd_pop) begin
                    case (i_cmd.kind)
                        CMD_LABEL: n_state = ST_LEN;
                        CMD_TERM:  n_state = ST_TERM;
                        default:   n_state = ST_ERR;
                    endcase
                end
            end
            ST_LEN: begin
                direct_res = '{out_byte: r_cmd.len, end_of_name: 1'b0,
                               err_code: ERR_NONE};
                if (can_direct) begin
                    direct  = 1'b1;
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                if (o_re && last_rd) begin
                    n_state = r_cmd.last ? ST_TERM : ST_IDLE;
                end
            end
            ST_TERM: begin
                if (can_direct) begin
                    direct  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                direct_res.err_code = r_cmd.err;
                if (can_direct) begin
                    direct  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign oq_wr  = r_rd_pend | direct;
    assign wr_res = r_rd_pend ?
                    t_res'{out_byte: i_rdata, end_of_name: 1'b0, err_code: ERR_NONE} :
                    direct_res;
    assign oq_rd  = i_pop & ~o_empty;

    assign o_empty       = (r_ocnt == '0);
    assign o_out_byte    = r_oq[r_orp].out_byte;
    assign o_end_of_name = r_oq[r_orp].end_of_name;
    assign o_err_code    = r_oq[r_orp].err_code;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_LEN) begin
            r_idx <= '0;
        end else if (o_re) begin
            r_idx <= r_idx + LCW'(1);
        end
        if (oq_wr) begin
            r_oq[r_owp] <= wr_res;
        end
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_pend <= 1'b0;
            r_owp     <= '0;
            r_orp     <= '0;
            r_ocnt    <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= o_re;
            if (oq_wr) begin
                r_owp <= r_owp + OPW'(1);
            end
            if (oq_rd) begin
                r_orp <= r_orp + OPW'(1);
            end
            r_ocnt <= r_ocnt + (OPW+1)'(oq_wr) - (OPW+1)'(oq_rd);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dns_name_label_encoder.sv =====
// dns_name_label_encoder: the front takes one character a cycle unless the command
// queue is full or both label banks are still being replayed. The back fetches a
// command, emits the length byte, replays the label bytes from the label RAM and,
// after the last label of a name, emits the terminator. A length byte reaches the
// outputs once its command has passed the command queue and the back's length state.
// Synchronous active-low reset empties both queues; RAM is not cleared.
`default_nettype none
module dns_name_label_encoder import dnle_pkg::*; #(
    parameter int unsigned MAX_LABEL   = 62,
    parameter int unsigned MAX_ENCODED = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    output logic        o_full,
    input  wire [7:0]   i_ch,
    input  wire         i_final_char,
    input  wire         i_pop,
    output logic        o_empty,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_name,
    output logic [1:0]  o_err_code
);
    localparam int unsigned LCW = $clog2(MAX_LABEL + 1);

    t_q_status        q_status;
    t_cmd             cmd_in, cmd_out;
    logic             cmd_push, cmd_pop;
    t_release         release_bank;
    logic             we, re;
    logic [LCW:0]     waddr, raddr;
    logic [7:0]       wdata, rdata;

    dnle_front #(.MAX_LABEL(MAX_LABEL), .MAX_ENCODED(MAX_ENCODED)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .i_ch(i_ch), .i_final_char(i_final_char), .o_full(o_full),
        .i_q_status(q_status), .o_cmd_push(cmd_push), .o_cmd(cmd_in),
        .i_release(release_bank),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata)
    );

    dnle_cmdq u_cmdq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(cmd_push), .i_cmd(cmd_in),
        .i_pop(cmd_pop), .o_cmd(cmd_out), .o_status(q_status)
    );

    dnle_ram #(.WIDTH(8), .DEPTH(2 ** (LCW + 1))) u_ram (
        .i_clk(i_clk),
        .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_re(re), .i_raddr(raddr), .o_rdata(rdata)
    );

    dnle_back #(.MAX_LABEL(MAX_LABEL)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_status(q_status), .i_cmd(cmd_out), .o_cmd_pop(cmd_pop),
        .o_release(release_bank),
        .o_re(re), .o_raddr(raddr), .i_rdata(rdata),
        .i_pop(i_pop), .o_empty(o_empty), .o_out_byte(o_out_byte),
        .o_end_of_name(o_end_of_name), .o_err_code(o_err_code)
    );

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_err_code != ERR_NONE) |-> (o_end_of_name && o_out_byte == 8'd0))
        else $error("error result without end of name");

    a_no_bank_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && re) |-> (waddr[LCW] != raddr[LCW]))
        else $error("label write into bank being replayed");

    a_cmdq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !q_status.full)
        else $error("command queue overflow");

    a_cmdq_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !q_status.empty)
        else $error("command queue underflow");
endmodule
`default_nettype wire
